### rtl/slo_pkg.sv
// Shared types, constants and constant functions for the scintillator light output core.
// Depends on nothing; every other file imports it.
`default_nettype none

package slo_pkg;

   localparam int FRAC_BITS = 12;
   localparam int INT_BITS  = 10;
   localparam int TW        = INT_BITS + FRAC_BITS;

   // Q.30 internal scaling and length of the bit-serial chains
   localparam int QB    = 30;
   localparam int STEPS = QB;

   localparam int LW  = ((INT_BITS + 31 > 38) ? INT_BITS + 31 : 38) + 1;
   localparam int PWW = INT_BITS + 31;
   localparam int VW  = PWW + 1;
   localparam int IPW = 7;
   localparam int PBW = 6;

   localparam longint unsigned ONE_Q = 64'd1 << QB;

   localparam logic [2:0] SPC_LEPTON   = 3'd0;
   localparam logic [2:0] SPC_PROTON   = 3'd1;
   localparam logic [2:0] SPC_DEUTERON = 3'd2;
   localparam logic [2:0] SPC_TRITON   = 3'd3;
   localparam logic [2:0] SPC_HE3      = 3'd4;
   localparam logic [2:0] SPC_ALPHA    = 3'd5;

   localparam logic [6:0] Z_LI = 7'd3;
   localparam logic [6:0] Z_BE = 7'd4;
   localparam logic [6:0] Z_B  = 7'd5;

   typedef struct packed {
      logic [30:0] a1;
      logic [36:0] a2;
      logic [30:0] a3;
      logic [30:0] a4;
   } coef_type;

   typedef struct packed {
      coef_type                c;
      logic                    zero;
      logic signed [LW-1:0]    lin;
      logic signed [IPW-1:0]   ipart;
      logic signed [IPW-1:0]   n;
      logic                    ebig;
      logic                    ezero;
      logic [5:0]              eshift;
   } side_type;

   localparam logic [30:0] LOG2E_Q =
      31'((64'd1442695041 * ONE_Q + 64'd500000000) / 64'd1000000000);

   localparam coef_type COEF_LEPTON = '{a1: 31'(ONE_Q), a2: '0, a3: '0, a4: '0};
   localparam coef_type COEF_PROTON = '{
      a1: 31'((64'd902713 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd755009 * ONE_Q + 64'd50000) / 64'd100000),
      a3: 31'((64'd990013 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd736281 * ONE_Q + 64'd500000) / 64'd1000000)};
   localparam coef_type COEF_DEUTERON = '{
      a1: 31'((64'd891575 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd122122 * ONE_Q + 64'd5000) / 64'd10000),
      a3: 31'((64'd702262 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd782977 * ONE_Q + 64'd500000) / 64'd1000000)};
   localparam coef_type COEF_TRITON = '{
      a1: 31'((64'd881489 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd159064 * ONE_Q + 64'd5000) / 64'd10000),
      a3: 31'((64'd564987 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd811916 * ONE_Q + 64'd500000) / 64'd1000000)};
   localparam coef_type COEF_HE3 = '{
      a1: 31'((64'd803919 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd344153 * ONE_Q + 64'd5000) / 64'd10000),
      a3: 31'((64'd254322 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd894859 * ONE_Q + 64'd500000) / 64'd1000000)};
   localparam coef_type COEF_ALPHA = '{
      a1: 31'((64'd781501 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd393133 * ONE_Q + 64'd5000) / 64'd10000),
      a3: 31'((64'd217115 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd910333 * ONE_Q + 64'd500000) / 64'd1000000)};
   localparam coef_type COEF_LI = '{
      a1: 31'((64'd613491 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd571372 * ONE_Q + 64'd5000) / 64'd10000),
      a3: 31'((64'd115948 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd951875 * ONE_Q + 64'd500000) / 64'd1000000)};
   localparam coef_type COEF_BE = '{
      a1: 31'((64'd435772 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd45538 * ONE_Q + 64'd500) / 64'd1000),
      a3: 31'((64'd104221 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd916373 * ONE_Q + 64'd500000) / 64'd1000000)};
   localparam coef_type COEF_B = '{
      a1: 31'((64'd350273 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd344664 * ONE_Q + 64'd5000) / 64'd10000),
      a3: 31'((64'd112395 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd912711 * ONE_Q + 64'd500000) / 64'd1000000)};
   localparam coef_type COEF_C12 = '{
      a1: 31'((64'd298394 * ONE_Q + 64'd500000) / 64'd1000000),
      a2: 37'((64'd255679 * ONE_Q + 64'd5000) / 64'd10000),
      a3: 31'((64'd130345 * ONE_Q + 64'd5000000) / 64'd10000000),
      a4: 31'((64'd908512 * ONE_Q + 64'd500000) / 64'd1000000)};

   function automatic coef_type coef_sel(input logic [2:0] species, input logic [6:0] z);
      coef_type c;
      unique case (species)
         SPC_LEPTON:   c = COEF_LEPTON;
         SPC_PROTON:   c = COEF_PROTON;
         SPC_DEUTERON: c = COEF_DEUTERON;
         SPC_TRITON:   c = COEF_TRITON;
         SPC_HE3:      c = COEF_HE3;
         SPC_ALPHA:    c = COEF_ALPHA;
         default: begin
            priority if (z == Z_LI) c = COEF_LI;
            else if (z == Z_BE)     c = COEF_BE;
            else if (z == Z_B)      c = COEF_B;
            else                    c = COEF_C12;
         end
      endcase
      return c;
   endfunction

   // elaboration-time integer square root, used only for the root table
   function automatic longint unsigned isqrt(input longint unsigned x);
      longint unsigned res;
      longint unsigned bit_v;
      longint unsigned rem;
      res   = 0;
      bit_v = 64'd1 << 62;
      rem   = x;
      for (int i = 0; i < 32; i++) begin
         if (bit_v > rem) bit_v = bit_v >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_v != 0) begin
            if (rem >= res + bit_v) begin
               rem = rem - (res + bit_v);
               res = (res >> 1) + bit_v;
            end else begin
               res = res >> 1;
            end
            bit_v = bit_v >> 2;
         end
      end
      return res;
   endfunction

   // 2^(2^-k) in Q.30, by repeated truncated square roots from 2.0
   function automatic longint unsigned exp2_root(input int k);
      longint unsigned r;
      r = ONE_Q << 1;
      for (int j = 1; j <= STEPS; j++) begin
         if (j <= k) r = isqrt(r << QB);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/scintillator_light_output_core.sv
// Top level of the scintillator light output core: input stage, two lanes, merge.
// Depends on slo_pkg, slo_lane, slo_merge.
`default_nettype none

// Converts a step's entry and exit kinetic energy into deposited light in MeVee.
// The pipeline takes one beat per cycle while the result side does not stall; its depth
// comes from the two 30-stage exponent chains and the 30-stage log chain in each lane.
// Entry and exit energies run in two identical lanes side by side. The whole
// pipeline holds while a result waits, so req_ready drops only in that case.

module scintillator_light_output_core import slo_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TW-1:0]       req_kinetic_in,
   input  logic signed [TW:0]  req_kinetic_out,
   input  logic [2:0]          req_species,
   input  logic [6:0]          req_charge_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [TW-1:0]       rsp_light_out
);

   logic                 en;
   logic                 in_valid_ff;
   logic [TW-1:0]        tin_ff;
   logic [TW-1:0]        tout_ff;
   coef_type             coef_ff;
   logic [TW-1:0]        tout_in;
   logic                 lane_in_valid;
   logic                 lane_out_valid;
   logic signed [LW-1:0] light_in_l;
   logic signed [LW-1:0] light_out_l;

   assign en        = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign tout_in   = req_kinetic_out[TW] ? '0 : req_kinetic_out[TW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tin_ff  <= req_kinetic_in;
         tout_ff <= tout_in;
         coef_ff <= coef_sel(req_species, req_charge_z);
      end
   end

   slo_lane u_lane_in (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid_ff),
      .in_t      (tin_ff),
      .in_coef   (coef_ff),
      .out_valid (lane_in_valid),
      .out_light (light_in_l)
   );

   slo_lane u_lane_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_valid_ff),
      .in_t      (tout_ff),
      .in_coef   (coef_ff),
      .out_valid (lane_out_valid),
      .out_light (light_out_l)
   );

   slo_merge u_merge (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (lane_in_valid && lane_out_valid),
      .in_light_in  (light_in_l),
      .in_light_out (light_out_l),
      .out_valid    (rsp_valid),
      .out_light    (rsp_light_out)
   );

endmodule

`default_nettype wire

### rtl/slo_log2.sv
// Fractional log2 by repeated squaring: one squaring and one result bit per stage.
// Depends on slo_pkg.
`default_nettype none

module slo_log2 import slo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [30:0]     in_m,
   input  side_type        in_side,
   output logic            out_valid,
   output logic [QB-1:0]   out_frac,
   output side_type        out_side
);

   logic            valid_ff [STEPS];
   logic [30:0]     m_ff     [STEPS];
   logic [QB-1:0]   frac_ff  [STEPS];
   side_type        side_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic          v_prev;
      logic [30:0]   m_prev;
      logic [QB-1:0] f_prev;
      side_type      s_prev;
      logic [61:0]   sq;
      logic [31:0]   sq_hi;
      logic [30:0]   m_in;
      logic [QB-1:0] frac_in;

      if (k == 0) begin : g_first
         assign v_prev = in_valid;
         assign m_prev = in_m;
         assign f_prev = '0;
         assign s_prev = in_side;
      end else begin : g_next
         assign v_prev = valid_ff[k-1];
         assign m_prev = m_ff[k-1];
         assign f_prev = frac_ff[k-1];
         assign s_prev = side_ff[k-1];
      end

      assign sq      = 62'(m_prev) * 62'(m_prev);
      assign sq_hi   = sq[61:30];
      // square reached 2.0 or more: emit a one and renormalize
      assign m_in    = sq_hi[31] ? sq_hi[31:1] : sq_hi[30:0];
      assign frac_in = {f_prev[QB-2:0], sq_hi[31]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[k]    <= m_in;
            frac_ff[k] <= frac_in;
            side_ff[k] <= s_prev;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_frac  = frac_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

### rtl/slo_exp2.sv
// 2^f for a Q.30 fraction: one conditional multiply by a constant root per stage.
// Depends on slo_pkg.
`default_nettype none

module slo_exp2 import slo_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [QB-1:0]   in_f,
   input  side_type        in_side,
   output logic            out_valid,
   output logic [30:0]     out_m,
   output side_type        out_side
);

   logic            valid_ff [STEPS];
   logic [30:0]     x_ff     [STEPS];
   logic [QB-1:0]   f_ff     [STEPS];
   side_type        side_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      localparam logic [30:0] ROOT = 31'(exp2_root(k + 1));
      logic          v_prev;
      logic [30:0]   x_prev;
      logic [QB-1:0] f_prev;
      side_type      s_prev;
      logic [61:0]   prod;
      logic [30:0]   x_in;
      logic [QB-1:0] f_in;

      if (k == 0) begin : g_first
         assign v_prev = in_valid;
         assign x_prev = 31'(ONE_Q);
         assign f_prev = in_f;
         assign s_prev = in_side;
      end else begin : g_next
         assign v_prev = valid_ff[k-1];
         assign x_prev = x_ff[k-1];
         assign f_prev = f_ff[k-1];
         assign s_prev = side_ff[k-1];
      end

      assign prod = 62'(x_prev) * 62'(ROOT);
      assign x_in = f_prev[QB-1] ? prod[60:30] : x_prev;
      assign f_in = {f_prev[QB-2:0], 1'b0};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= x_in;
            f_ff[k]    <= f_in;
            side_ff[k] <= s_prev;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_m     = x_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

### rtl/slo_lane.sv
// One light-curve lane: L(T) = a1*T - a2*(1 - exp(-a3*T^a4)) in signed Q.30.
// Depends on slo_pkg, slo_log2, slo_exp2.
`default_nettype none

module slo_lane import slo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [TW-1:0]        in_t,
   input  coef_type             in_coef,
   output logic                 out_valid,
   output logic signed [LW-1:0] out_light
);

   // normalize and linear term
   logic [PBW-1:0]   lead;
   logic [TW+29:0]   wide;
   logic [TW+30:0]   lin_prod;
   side_type         s0_side_in;
   logic             s0_valid_ff;
   logic [30:0]      s0_m_ff;
   side_type         s0_side_ff;

   always_comb begin
      lead = '0;
      for (int i = 0; i < TW; i++) begin
         if (in_t[i]) lead = PBW'(i);
      end
   end

   assign wide     = {in_t, 30'b0} >> lead;
   assign lin_prod = (TW+31)'(in_t) * (TW+31)'(in_coef.a1);

   always_comb begin
      s0_side_in        = '0;
      s0_side_in.c      = in_coef;
      s0_side_in.zero   = (in_t == '0);
      s0_side_in.lin    = LW'(lin_prod >> FRAC_BITS);
      s0_side_in.ipart  = IPW'(lead) - IPW'(FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_m_ff    <= wide[30:0];
         s0_side_ff <= s0_side_in;
      end
   end

   logic            lg_valid;
   logic [QB-1:0]   lg_frac;
   side_type        lg_side;

   slo_log2 u_log2 (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_m      (s0_m_ff),
      .in_side   (s0_side_ff),
      .out_valid (lg_valid),
      .out_frac  (lg_frac),
      .out_side  (lg_side)
   );

   // y = a4 * log2(T), multiplied in sign-magnitude with the magnitude truncated
   logic [36:0]  lg_val;
   logic [36:0]  lg_mag;
   logic [37:0]  y_hi;
   logic [60:0]  y_lo;
   logic [37:0]  y_mag;
   logic [37:0]  y_in;
   logic         y_valid_ff;
   logic [37:0]  y_ff;
   side_type     y_side_ff;
   side_type     e1_side_in;

   assign lg_val = {lg_side.ipart, lg_frac};
   assign lg_mag = lg_val[36] ? (~lg_val + 37'd1) : lg_val;
   assign y_hi   = 38'(lg_mag[36:30]) * 38'(lg_side.c.a4);
   assign y_lo   = 61'(lg_mag[29:0]) * 61'(lg_side.c.a4);
   assign y_mag  = y_hi + 38'(y_lo >> 30);
   assign y_in   = lg_val[36] ? (~y_mag + 38'd1) : y_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         y_valid_ff <= 1'b0;
      end else if (en) begin
         y_valid_ff <= lg_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y_ff      <= y_in;
         y_side_ff <= lg_side;
      end
   end

   always_comb begin
      e1_side_in   = y_side_ff;
      e1_side_in.n = y_ff[36:30];   // floor of y; |y| stays well below 64
   end

   logic         e1_valid;
   logic [30:0]  e1_m;
   side_type     e1_side;

   slo_exp2 u_exp2_pow (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (y_valid_ff),
      .in_f      (y_ff[29:0]),
      .in_side   (e1_side_in),
      .out_valid (e1_valid),
      .out_m     (e1_m),
      .out_side  (e1_side)
   );

   // T^a4 = 2^frac scaled by the integer part
   logic [IPW-1:0] n_neg;
   logic [PWW-1:0] pw_in;
   logic           pw_valid_ff;
   logic [PWW-1:0] pw_ff;
   side_type       pw_side_ff;

   assign n_neg = IPW'(-e1_side.n);
   assign pw_in = e1_side.n[IPW-1] ? (PWW'(e1_m) >> n_neg)
                                   : (PWW'(e1_m) << IPW'(e1_side.n));

   always_ff @(posedge clock) begin
      if (reset) begin
         pw_valid_ff <= 1'b0;
      end else if (en) begin
         pw_valid_ff <= e1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pw_ff      <= pw_in;
         pw_side_ff <= e1_side;
      end
   end

   // u = a3 * T^a4
   logic [PWW+30:0] u_hi;
   logic [60:0]     u_lo;
   logic [PWW-1:0]  u_in;
   logic            u_valid_ff;
   logic [PWW-1:0]  u_ff;
   side_type        u_side_ff;

   assign u_hi = (PWW+31)'(pw_ff[PWW-1:30]) * (PWW+31)'(pw_side_ff.c.a3);
   assign u_lo = 61'(pw_ff[29:0]) * 61'(pw_side_ff.c.a3);
   assign u_in = PWW'(u_hi + (PWW+31)'(u_lo >> 30));

   always_ff @(posedge clock) begin
      if (reset) begin
         u_valid_ff <= 1'b0;
      end else if (en) begin
         u_valid_ff <= pw_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff      <= u_in;
         u_side_ff <= pw_side_ff;
      end
   end

   // v = u * log2(e), so exp(-u) = 2^-v
   logic [VW+30:0]  v_hi;
   logic [60:0]     v_lo;
   logic [VW-1:0]   v_in;
   logic            v_valid_ff;
   logic [VW-1:0]   v_ff;
   side_type        v_side_ff;

   assign v_hi = (VW+31)'(u_ff[PWW-1:30]) * (VW+31)'(LOG2E_Q);
   assign v_lo = 61'(u_ff[29:0]) * 61'(LOG2E_Q);
   assign v_in = VW'(v_hi + (VW+31)'(v_lo >> 30));

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
      end else if (en) begin
         v_valid_ff <= u_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff      <= v_in;
         v_side_ff <= u_side_ff;
      end
   end

   // split v: integer part is a right shift, 2^-frac = 2^(1-frac)/2
   side_type        g_side_in;
   logic [QB-1:0]   g_in;
   logic            g_valid_ff;
   logic [QB-1:0]   g_ff;
   side_type        g_side_ff;

   always_comb begin
      g_side_in        = v_side_ff;
      g_side_in.ebig   = (v_ff >= (VW'(40) << QB));
      g_side_in.eshift = v_ff[35:30];
      g_side_in.ezero  = (v_ff[29:0] == '0);
   end

   assign g_in = ~v_ff[29:0] + 30'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (en) begin
         g_valid_ff <= v_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_ff      <= g_in;
         g_side_ff <= g_side_in;
      end
   end

   logic         e2_valid;
   logic [30:0]  e2_m;
   side_type     e2_side;

   slo_exp2 u_exp2_neg (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid_ff),
      .in_f      (g_ff),
      .in_side   (g_side_ff),
      .out_valid (e2_valid),
      .out_m     (e2_m),
      .out_side  (e2_side)
   );

   // b = 1 - exp(-u)
   logic [30:0]  m2;
   logic [30:0]  ex;
   logic [30:0]  b_in;
   logic         b_valid_ff;
   logic [30:0]  b_ff;
   side_type     b_side_ff;

   assign m2   = e2_side.ezero ? 31'(ONE_Q) : {1'b0, e2_m[30:1]};
   assign ex   = e2_side.ebig ? '0 : (m2 >> e2_side.eshift);
   assign b_in = 31'(ONE_Q) - ex;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff <= e2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_ff      <= b_in;
         b_side_ff <= e2_side;
      end
   end

   // L = lin - a2*b; zero energy gives zero light
   logic [37:0]           t_hi;
   logic [60:0]           t_lo;
   logic [37:0]           term;
   logic signed [LW-1:0]  light_in;
   logic                  light_valid_ff;
   logic signed [LW-1:0]  light_ff;

   assign t_hi     = 38'(b_side_ff.c.a2[36:30]) * 38'(b_ff);
   assign t_lo     = 61'(b_side_ff.c.a2[29:0]) * 61'(b_ff);
   assign term     = t_hi + 38'(t_lo >> 30);
   assign light_in = b_side_ff.zero ? '0 : (b_side_ff.lin - $signed(LW'(term)));

   always_ff @(posedge clock) begin
      if (reset) begin
         light_valid_ff <= 1'b0;
      end else if (en) begin
         light_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         light_ff <= light_in;
      end
   end

   assign out_valid = light_valid_ff;
   assign out_light = light_ff;

endmodule

`default_nettype wire

### rtl/slo_merge.sv
// Combines the entry and exit lanes: difference, clamp at zero, rescale, saturate.
// Holds the result register. Depends on slo_pkg.
`default_nettype none

module slo_merge import slo_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [LW-1:0] in_light_in,
   input  logic signed [LW-1:0] in_light_out,
   output logic                 out_valid,
   output logic [TW-1:0]        out_light
);

   logic signed [LW:0] diff;
   logic [LW:0]        pos;
   logic [LW:0]        scaled;
   logic [TW-1:0]      light_in;
   logic               valid_ff;
   logic [TW-1:0]      light_ff;

   assign diff     = (LW+1)'(in_light_in) - (LW+1)'(in_light_out);
   assign pos      = diff[LW] ? '0 : diff;
   assign scaled   = pos >> (QB - FRAC_BITS);
   assign light_in = (scaled > (LW+1)'({TW{1'b1}})) ? {TW{1'b1}} : scaled[TW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         light_ff <= light_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_light = light_ff;

endmodule

`default_nettype wire

### rtl/slo_checker.sv
// Port-level checks for scintillator_light_output_core, bound to the top level.
// Depends on slo_pkg.
`default_nettype none

module slo_checker import slo_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [TW-1:0]      req_kinetic_in,
   input logic signed [TW:0] req_kinetic_out,
   input logic [2:0]         req_species,
   input logic [6:0]         req_charge_z,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [TW-1:0]      rsp_light_out
);

   // a waiting request beat keeps its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_kinetic_in)
         && $stable(req_kinetic_out) && $stable(req_species) && $stable(req_charge_z))
      else $error("request beat changed while waiting");

   // a waiting result beat keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_light_out))
      else $error("result beat changed while stalled");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // pipeline holds exactly when a result is stuck
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipeline stalled");

   a_free_runs: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("request side blocked without a stall");

endmodule

bind scintillator_light_output_core slo_checker u_slo_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_kinetic_in  (req_kinetic_in),
   .req_kinetic_out (req_kinetic_out),
   .req_species     (req_species),
   .req_charge_z    (req_charge_z),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_light_out   (rsp_light_out)
);

`default_nettype wire
